FILE: design/rrs_pkg.sv
// Package for the round-robin slice scheduler: codes, widths and defaults.
package rrs_pkg;

  localparam int MAX_PROCS_DEF = 64;
  localparam int DATA_W        = 16;
  localparam int ELAPSED_W     = 22;
  localparam logic [DATA_W-1:0] QUANTUM_RST = 16'd4;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_SLICE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

endpackage

FILE: design/rrs_ram.sv
// Generic single-port RAM with registered read.
module rrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/round_robin_slice_scheduler.sv
// Round-robin time-slice scheduler: process table, slice selection and results.
//
// Every accepted item gives one result, shown for one cycle with out_valid high;
// the receiver cannot stall, so results must be taken when they appear. The result
// of a load, clear or unused code appears in the next cycle. A slice item that finds
// a process reads the remaining-time memory in the accept cycle and writes it back
// in the next one, during which busy is high; its result appears in the cycle after
// the write-back. A slice that finds nothing pending gives its result in the next
// cycle as well. No clearing pass follows reset.
// The quantum may be written whenever the block is idle.
module round_robin_slice_scheduler #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF,
  localparam int IDX_W = $clog2(MAX_PROCS),
  localparam int CNT_W = $clog2(MAX_PROCS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_func,
  input  logic [rrs_pkg::DATA_W-1:0]  in_burst_time,
  input  logic                        cfg_we,
  input  logic [rrs_pkg::DATA_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [CNT_W-1:0]            out_process_id,
  output logic [rrs_pkg::DATA_W-1:0]  out_run_length,
  output logic [rrs_pkg::ELAPSED_W-1:0] out_elapsed_time,
  output logic                        out_all_done
);

  localparam int DW = rrs_pkg::DATA_W;
  localparam int EW = rrs_pkg::ELAPSED_W;

  rrs_pkg::state_t state_r, state_nxt;
  logic [MAX_PROCS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     next_slot_r, next_slot_nxt;
  logic [EW-1:0]        total_r, total_nxt;
  logic [DW-1:0]        quantum_r, quantum_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic                 valid_r, valid_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [CNT_W-1:0]     pid_r, pid_nxt;
  logic [DW-1:0]        run_r, run_nxt;
  logic [EW-1:0]        elapsed_r, elapsed_nxt;
  logic                 done_r, done_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [DW-1:0]        ram_wdata, ram_rdata;

  logic [MAX_PROCS-1:0] hi_mask;
  logic                 hi_found, any_found, found;
  logic [IDX_W-1:0]     hi_idx, any_idx, search_idx;
  logic [DW-1:0]        q_eff, run_val, rem_new;
  logic [EW:0]          total_sum;
  logic [CNT_W-1:0]     idx_inc;
  logic                 accept;

  rrs_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_PROCS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // rotating priority encoder: first pending slot at or after next_slot, else first
  always_comb begin
    hi_found = 1'b0;
    any_found = 1'b0;
    hi_idx = '0;
    any_idx = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      hi_mask[i] = mask_r[i] && (IDX_W'(i) >= next_slot_r);
    end
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (hi_mask[i]) begin
        hi_found = 1'b1;
        hi_idx = IDX_W'(i);
      end
      if (mask_r[i]) begin
        any_found = 1'b1;
        any_idx = IDX_W'(i);
      end
    end
    found = any_found;
    search_idx = hi_found ? hi_idx : any_idx;
  end

  assign accept = start && !busy;
  assign busy = (state_r == rrs_pkg::ST_UPD);

  always_comb begin
    q_eff = (quantum_r == '0) ? DW'(1) : quantum_r;
    run_val = (ram_rdata < q_eff) ? ram_rdata : q_eff;
    rem_new = ram_rdata - run_val;
    total_sum = {1'b0, total_r} + (EW + 1)'(run_val);
    idx_inc = CNT_W'(idx_r) + CNT_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    mask_nxt = mask_r;
    count_nxt = count_r;
    next_slot_nxt = next_slot_r;
    total_nxt = total_r;
    quantum_nxt = cfg_we ? cfg_wdata : quantum_r;
    idx_nxt = idx_r;
    valid_nxt = 1'b0;
    status_nxt = rrs_pkg::STATUS_OK;
    pid_nxt = '0;
    run_nxt = '0;
    elapsed_nxt = total_r;
    done_nxt = ~|mask_r;
    ram_we = 1'b0;
    ram_addr = search_idx;
    ram_wdata = in_burst_time;

    unique case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            rrs_pkg::FUNC_LOAD: begin
              valid_nxt = 1'b1;
              if (count_r >= CNT_W'(MAX_PROCS)) begin
                status_nxt = rrs_pkg::STATUS_FULL;
              end else begin
                ram_we = 1'b1;
                ram_addr = count_r[IDX_W-1:0];
                mask_nxt[count_r[IDX_W-1:0]] = (in_burst_time != '0);
                count_nxt = count_r + CNT_W'(1);
                pid_nxt = count_r + CNT_W'(1);
                done_nxt = ~|mask_nxt;
              end
            end
            rrs_pkg::FUNC_SLICE: begin
              if (found) begin
                idx_nxt = search_idx;
                state_nxt = rrs_pkg::ST_UPD;
              end else begin
                valid_nxt = 1'b1;
                status_nxt = rrs_pkg::STATUS_NONE;
              end
            end
            rrs_pkg::FUNC_CLEAR: begin
              valid_nxt = 1'b1;
              mask_nxt = '0;
              count_nxt = '0;
              next_slot_nxt = '0;
              total_nxt = '0;
              elapsed_nxt = '0;
              done_nxt = 1'b1;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      rrs_pkg::ST_UPD: begin
        ram_we = 1'b1;
        ram_addr = idx_r;
        ram_wdata = rem_new;
        if (rem_new == '0) begin
          mask_nxt[idx_r] = 1'b0;
        end
        total_nxt = total_sum[EW] ? {EW{1'b1}} : total_sum[EW-1:0];
        next_slot_nxt = (idx_inc >= count_r) ? '0 : idx_inc[IDX_W-1:0];
        valid_nxt = 1'b1;
        pid_nxt = idx_inc;
        run_nxt = run_val;
        elapsed_nxt = total_nxt;
        done_nxt = ~|mask_nxt;
        state_nxt = rrs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrs_pkg::ST_IDLE;
      mask_r <= '0;
      count_r <= '0;
      next_slot_r <= '0;
      total_r <= '0;
      quantum_r <= rrs_pkg::QUANTUM_RST;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mask_r <= mask_nxt;
      count_r <= count_nxt;
      next_slot_r <= next_slot_nxt;
      total_r <= total_nxt;
      quantum_r <= quantum_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    status_r <= status_nxt;
    pid_r <= pid_nxt;
    run_r <= run_nxt;
    elapsed_r <= elapsed_nxt;
    done_r <= done_nxt;
  end

  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_process_id = pid_r;
  assign out_run_length = run_r;
  assign out_elapsed_time = elapsed_r;
  assign out_all_done = done_r;

endmodule

FILE: tb/rrs_result_checker.sv
// Scheduler result checker: mirrors the process table and compares every result.
`timescale 1ns / 100ps
module rrs_result_checker
  import rrs_pkg::*;
#(
  localparam int PROCS = MAX_PROCS_DEF,
  localparam int PID_W = $clog2(MAX_PROCS_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [DATA_W-1:0]    in_burst_time,
  input  logic                 cfg_we,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 out_valid,
  input  logic [1:0]           out_status,
  input  logic [PID_W-1:0]     out_process_id,
  input  logic [DATA_W-1:0]    out_run_length,
  input  logic [ELAPSED_W-1:0] out_elapsed_time,
  input  logic                 out_all_done,
  output int                   fail_count,
  output int                   outstanding
);

  localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

  typedef struct packed {
    logic [1:0]           status;
    logic [PID_W-1:0]     pid;
    logic [DATA_W-1:0]    run_len;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 done;
  } sched_result_t;

  logic [DATA_W-1:0]    time_left [PROCS];
  logic [PROCS-1:0]     waiting_mask;
  int                   proc_total;
  int                   search_from;
  logic [ELAPSED_W-1:0] elapsed_sum;
  logic [DATA_W-1:0]    quantum;
  sched_result_t        expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic void clear_table();
    waiting_mask = '0;
    proc_total   = 0;
    search_from  = 0;
    elapsed_sum  = '0;
  endfunction

  function automatic sched_result_t schedule_predict(logic [1:0] func,
                                                     logic [DATA_W-1:0] burst);
    sched_result_t r;
    int idx;
    bit found;
    int q;
    int left;
    int run;
    longint sum;
    r = '0;
    found = 0;
    idx = 0;
    case (func)
      FUNC_LOAD: begin
        if (proc_total >= PROCS) begin
          r.status = STATUS_FULL;
        end else begin
          time_left[proc_total]    = burst;
          waiting_mask[proc_total] = (burst != 0);
          proc_total++;
          r.pid = PID_W'(proc_total);
        end
      end
      FUNC_SLICE: begin
        for (int k = 0; k < proc_total && !found; k++) begin
          idx = search_from + k;
          if (idx >= proc_total) idx -= proc_total;
          if (waiting_mask[idx]) found = 1;
        end
        if (!found) begin
          r.status = STATUS_NONE;
        end else begin
          q = (quantum == 0) ? 1 : int'(quantum);
          left = int'(time_left[idx]);
          run = (left < q) ? left : q;
          left -= run;
          time_left[idx] = DATA_W'(left);
          if (left == 0) waiting_mask[idx] = 1'b0;
          sum = longint'(elapsed_sum) + run;
          elapsed_sum = (sum > longint'(ELAPSED_SAT)) ? ELAPSED_SAT : ELAPSED_W'(sum);
          search_from = idx + 1;
          if (search_from >= proc_total) search_from = 0;
          r.pid = PID_W'(idx + 1);
          r.run_len = DATA_W'(run);
        end
      end
      FUNC_CLEAR: clear_table();
      default: ;
    endcase
    r.elapsed = elapsed_sum;
    r.done = (waiting_mask == '0);
    return r;
  endfunction

  task automatic report(string what, sched_result_t exp_r, sched_result_t got);
    if (fail_count < 10)
      $display({"%s: expected status=%0d id=%0d run=%0d elapsed=%0d done=%0b, ",
                "got status=%0d id=%0d run=%0d elapsed=%0d done=%0b"},
               what, exp_r.status, exp_r.pid, exp_r.run_len, exp_r.elapsed, exp_r.done,
               got.status, got.pid, got.run_len, got.elapsed, got.done);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t exp_r;
    if (!rst_n) begin
      clear_table();
      quantum = QUANTUM_RST;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        got = '{out_status, out_process_id, out_run_length, out_elapsed_time, out_all_done};
        if (expected_results.size() == 0) begin
          report("result with no item pending", '0, got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status || got.pid !== exp_r.pid ||
              got.run_len !== exp_r.run_len || got.elapsed !== exp_r.elapsed ||
              got.done !== exp_r.done)
            report("mismatch", exp_r, got);
        end
      end
      if (cfg_we) quantum = cfg_wdata;
      if (start && !busy)
        expected_results.push_back(schedule_predict(in_func, in_burst_time));
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the scheduler testbench: clock, reset, item stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb;
  import rrs_pkg::*;

  localparam int PID_W = $clog2(MAX_PROCS_DEF + 1);
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 950;
  localparam int IDLE_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [1:0]           in_func = FUNC_LOAD;
  logic [DATA_W-1:0]    in_burst_time = '0;
  logic                 cfg_we = 1'b0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [PID_W-1:0]     out_process_id;
  logic [DATA_W-1:0]    out_run_length;
  logic [ELAPSED_W-1:0] out_elapsed_time;
  logic                 out_all_done;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int idle_cycles = 0;
  int gap_odds = 3;
  bit big_done = 0;

  round_robin_slice_scheduler DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_burst_time    (in_burst_time),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_process_id   (out_process_id),
    .out_run_length   (out_run_length),
    .out_elapsed_time (out_elapsed_time),
    .out_all_done     (out_all_done)
  );

  rrs_result_checker results_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_burst_time    (in_burst_time),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_process_id   (out_process_id),
    .out_run_length   (out_run_length),
    .out_elapsed_time (out_elapsed_time),
    .out_all_done     (out_all_done),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue_item(input logic [1:0] func, input logic [DATA_W-1:0] burst);
    if (gap_odds != 0 && items_sent < ITEM_TARGET - 100 &&
        $urandom_range(1, gap_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_burst_time <= burst;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return DATA_W'($urandom_range(0, 12));
      6, 7, 8:          return DATA_W'($urandom_range(0, 400));
      default:          return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_quantum();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DATA_W'(1);
      2:       return DATA_W'(2);
      3:       return DATA_W'(3);
      4:       return DATA_W'(4);
      5:       return DATA_W'($urandom_range(5, 40));
      6:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    int n_procs;
    int n_slices;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, zero burst, extremes, wrap, clear
    issue_item(FUNC_UNUSED, '1);
    issue_item(FUNC_SLICE, '0);
    issue_item(FUNC_LOAD, '0);
    issue_item(FUNC_SLICE, '1);
    issue_item(FUNC_LOAD, '1);
    issue_item(FUNC_LOAD, DATA_W'(1));
    issue_item(FUNC_LOAD, DATA_W'(5));
    repeat (4) issue_item(FUNC_SLICE, DATA_W'(16'hA5C3));
    issue_item(FUNC_UNUSED, '0);
    issue_item(FUNC_CLEAR, '1);
    issue_item(FUNC_SLICE, '0);
    drain_results();
    write_quantum('0);
    issue_item(FUNC_LOAD, DATA_W'(3));
    repeat (4) issue_item(FUNC_SLICE, '0);
    drain_results();
    write_quantum('1);
    issue_item(FUNC_LOAD, '1);
    repeat (2) issue_item(FUNC_SLICE, '0);

    while (items_sent < ITEM_TARGET) begin
      drain_results();
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      if (!big_done && items_sent >= 300) begin
        // full table of long bursts drives the elapsed total near its top
        write_quantum('1);
        issue_item(FUNC_CLEAR, DATA_W'($urandom));
        repeat (MAX_PROCS_DEF + 2) issue_item(FUNC_LOAD, DATA_W'($urandom_range(60000, 65535)));
        repeat (MAX_PROCS_DEF + 2) issue_item(FUNC_SLICE, DATA_W'($urandom));
        big_done = 1;
      end else begin
        write_quantum(pick_quantum());
        issue_item(FUNC_CLEAR, DATA_W'($urandom));
        n_procs = ($urandom_range(0, 7) == 0) ? $urandom_range(60, MAX_PROCS_DEF + 2)
                                              : $urandom_range(1, 10);
        repeat (n_procs) issue_item(FUNC_LOAD, pick_burst());
        n_slices = $urandom_range(n_procs, 4 * n_procs + 12);
        repeat (n_slices) begin
          if ($urandom_range(0, 9) == 0)
            issue_item(2'($urandom_range(0, 3)), DATA_W'($urandom));
          else
            issue_item(FUNC_SLICE, DATA_W'($urandom));
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
